### hw/rtl/brb_pkg.sv
// ----------------------------------------------------------------------------
// brb_pkg
// Shared types and constants for the byte ring buffer FIFO: payload structs,
// command and status codes, controller states and the control bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package brb_pkg;

  // Number of physical slots in the ring store.
  localparam int MAX_SLOTS = 256;
  // Width of a slot index.
  localparam int IDX_W = $clog2(MAX_SLOTS);
  // Width that holds an effective ring length, 1 .. MAX_SLOTS.
  localparam int EL_W = $clog2(MAX_SLOTS + 1);

  // Field widths fixed by the interface.
  localparam int LEN_W = 9;
  localparam int BYTE_W = 8;
  localparam int CNT_W = 9;
  localparam int FILL_W = 8;
  // Room for an index plus a discard count.
  localparam int SUM_W = ((EL_W > CNT_W) ? EL_W : CNT_W) + 1;

  typedef enum logic [1:0] {
    CMD_PUSH    = 2'd0,
    CMD_POP     = 2'd1,
    CMD_PEEK    = 2'd2,
    CMD_DISCARD = 2'd3
  } brb_cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_OVER  = 2'd1,
    ST_UNDER = 2'd2
  } brb_status_t;

  typedef struct packed {
    brb_cmd_t           cmd;
    logic [BYTE_W-1:0]  push_byte;
    logic [CNT_W-1:0]   discard_count;
  } brb_in_t;

  typedef struct packed {
    brb_status_t        status;
    logic [BYTE_W-1:0]  read_byte;
    logic [FILL_W-1:0]  fill_level;
    logic               is_empty;
  } brb_out_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_EXEC = 2'd1,
    S_OUT  = 2'd2
  } brb_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;  // latch the item and read the oldest slot
    logic execute;  // update indices and store, load the result register
  } brb_ctl_t;

endpackage

`default_nettype wire

### hw/rtl/byte_ring_buffer_fifo.sv
// ----------------------------------------------------------------------------
// byte_ring_buffer_fifo
// Byte FIFO in a ring store with a programmable ring length.
// ----------------------------------------------------------------------------
// Each item carries a command (push, pop, peek or discard N) and returns
// exactly one result item with a status, the byte read, the fill level after
// the command and an empty flag. The block handles one item at a time: an
// item is captured, then executed, and its result is then shown until the
// result channel takes it; no new item is accepted before then, and a stall
// on the result channel holds off the next item. The controller holds a
// single item from acceptance until its result is taken: the registered read
// of the oldest slot is issued when the item is taken and consumed in the
// execute cycle, and the result register must be handed over before the next
// item is taken. The ring length register (1 to 256; 0 acts as 1 and larger
// values act as 256) clears both indices when written and must be written
// only while no item is in flight. One slot of the ring always stays unused,
// so the FIFO holds at most length minus one bytes. The store has no reset;
// only bytes that were pushed are ever read.
`default_nettype none

module byte_ring_buffer_fifo (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  // Command items.
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire brb_pkg::brb_in_t           in_item,
  // Result items.
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output brb_pkg::brb_out_t               out_item,
  // Ring length register.
  input  wire logic                       cfg_we,
  input  wire logic [brb_pkg::LEN_W-1:0]  cfg_wdata
);

  brb_pkg::brb_ctl_t ctl;

  // The controller paces items; the datapath owns all storage.
  brb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .ctl       (ctl)
  );

  brb_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .in_item   (in_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .out_item  (out_item)
  );

  // While a result is waiting, no new item is taken.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("item accepted while a result is pending");

  // An accepted item passes through its execute state and then shows a result.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> ##1 out_valid)
    else $error("result did not follow an accepted item");

  // The empty flag agrees with the fill level on every result.
  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.is_empty == (out_item.fill_level == '0)))
    else $error("empty flag disagrees with fill level");

endmodule

`default_nettype wire

### hw/rtl/brb_ctrl.sv
// ----------------------------------------------------------------------------
// brb_ctrl
// Controller of the byte ring buffer FIFO: sequences capture, execute and
// result hand-off for one item at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module brb_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output brb_pkg::brb_ctl_t      ctl
);

  brb_pkg::brb_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= brb_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    in_stall    = 1'b1;
    out_valid   = 1'b0;
    ctl.capture = 1'b0;
    ctl.execute = 1'b0;
    unique case (state_r)
      brb_pkg::S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          ctl.capture = 1'b1;
          state_nxt   = brb_pkg::S_EXEC;
        end
      end
      brb_pkg::S_EXEC: begin
        ctl.execute = 1'b1;
        state_nxt   = brb_pkg::S_OUT;
      end
      brb_pkg::S_OUT: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          state_nxt = brb_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = brb_pkg::S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

### hw/rtl/brb_dpath.sv
// ----------------------------------------------------------------------------
// brb_dpath
// Datapath of the byte ring buffer FIFO: ring length register, head and tail
// indices, the byte store and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module brb_dpath (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire brb_pkg::brb_ctl_t             ctl,
  input  wire brb_pkg::brb_in_t              in_item,
  input  wire logic                          cfg_we,
  input  wire logic [brb_pkg::LEN_W-1:0]     cfg_wdata,
  output brb_pkg::brb_out_t                  out_item
);

  logic [brb_pkg::LEN_W-1:0]   len_r;
  logic [brb_pkg::IDX_W-1:0]   wr_idx_r, wr_idx_nxt;
  logic [brb_pkg::IDX_W-1:0]   rd_idx_r, rd_idx_nxt;
  brb_pkg::brb_in_t            item_r;
  logic [brb_pkg::BYTE_W-1:0]  rd_data_r;
  brb_pkg::brb_out_t           res_r, res_nxt;
  logic                        store_we;

  logic [brb_pkg::BYTE_W-1:0]  mem [brb_pkg::MAX_SLOTS];

  logic [brb_pkg::EL_W-1:0]    eff_len;
  logic [brb_pkg::EL_W-1:0]    fill;
  logic [brb_pkg::EL_W-1:0]    wr_inc, rd_inc;
  logic [brb_pkg::SUM_W-1:0]   disc_sum, disc_wrap;

  // Length 0 acts as 1; lengths above the store size saturate.
  always_comb begin
    if (len_r == '0) begin
      eff_len = brb_pkg::EL_W'(1);
    end else if (brb_pkg::SUM_W'(len_r) > brb_pkg::SUM_W'(brb_pkg::MAX_SLOTS)) begin
      eff_len = brb_pkg::EL_W'(brb_pkg::MAX_SLOTS);
    end else begin
      eff_len = brb_pkg::EL_W'(len_r);
    end
  end

  always_comb begin
    fill = brb_pkg::EL_W'(wr_idx_r) - brb_pkg::EL_W'(rd_idx_r);
    if (wr_idx_r < rd_idx_r) begin
      fill = fill + eff_len;
    end
    wr_inc = brb_pkg::EL_W'(wr_idx_r) + brb_pkg::EL_W'(1);
    rd_inc = brb_pkg::EL_W'(rd_idx_r) + brb_pkg::EL_W'(1);
    disc_sum  = brb_pkg::SUM_W'(rd_idx_r) + brb_pkg::SUM_W'(item_r.discard_count);
    disc_wrap = disc_sum - brb_pkg::SUM_W'(eff_len);
  end

  always_comb begin
    wr_idx_nxt         = wr_idx_r;
    rd_idx_nxt         = rd_idx_r;
    store_we           = 1'b0;
    res_nxt.status     = brb_pkg::ST_OK;
    res_nxt.read_byte  = '0;
    res_nxt.fill_level = brb_pkg::FILL_W'(fill);
    unique case (item_r.cmd)
      brb_pkg::CMD_PUSH: begin
        if (fill + brb_pkg::EL_W'(1) >= eff_len) begin
          res_nxt.status = brb_pkg::ST_OVER;
        end else begin
          store_we           = 1'b1;
          wr_idx_nxt         = (wr_inc == eff_len) ? '0 : brb_pkg::IDX_W'(wr_inc);
          res_nxt.fill_level = brb_pkg::FILL_W'(fill + brb_pkg::EL_W'(1));
        end
      end
      brb_pkg::CMD_POP, brb_pkg::CMD_PEEK: begin
        if (fill == '0) begin
          res_nxt.status = brb_pkg::ST_UNDER;
        end else begin
          res_nxt.read_byte = rd_data_r;
          if (item_r.cmd == brb_pkg::CMD_POP) begin
            rd_idx_nxt         = (rd_inc == eff_len) ? '0 : brb_pkg::IDX_W'(rd_inc);
            res_nxt.fill_level = brb_pkg::FILL_W'(fill - brb_pkg::EL_W'(1));
          end
        end
      end
      brb_pkg::CMD_DISCARD: begin
        if (brb_pkg::SUM_W'(item_r.discard_count) > brb_pkg::SUM_W'(fill)) begin
          res_nxt.status = brb_pkg::ST_UNDER;
        end else begin
          rd_idx_nxt = (disc_sum >= brb_pkg::SUM_W'(eff_len))
                       ? brb_pkg::IDX_W'(disc_wrap) : brb_pkg::IDX_W'(disc_sum);
          res_nxt.fill_level = brb_pkg::FILL_W'(brb_pkg::SUM_W'(fill)
                                                - brb_pkg::SUM_W'(item_r.discard_count));
        end
      end
      default: begin
        res_nxt.status = brb_pkg::ST_OK;
      end
    endcase
    res_nxt.is_empty = (res_nxt.fill_level == '0);
  end

  // A ring length write clears both indices and takes precedence.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r    <= brb_pkg::LEN_W'(brb_pkg::MAX_SLOTS);
      wr_idx_r <= '0;
      rd_idx_r <= '0;
    end else if (cfg_we) begin
      len_r    <= cfg_wdata;
      wr_idx_r <= '0;
      rd_idx_r <= '0;
    end else if (ctl.execute) begin
      wr_idx_r <= wr_idx_nxt;
      rd_idx_r <= rd_idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      item_r <= in_item;
    end
    if (ctl.execute) begin
      res_r <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      rd_data_r <= mem[rd_idx_r];
    end
    if (ctl.execute && store_we) begin
      mem[wr_idx_r] <= item_r.push_byte;
    end
  end

  assign out_item = res_r;

  a_cfg_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> (wr_idx_r == '0 && rd_idx_r == '0))
    else $error("ring length write did not clear the indices");

  a_wr_in_ring: assert property (@(posedge clk) disable iff (!rst_n)
    brb_pkg::EL_W'(wr_idx_r) < eff_len)
    else $error("write index outside the ring");

  a_rd_in_ring: assert property (@(posedge clk) disable iff (!rst_n)
    brb_pkg::EL_W'(rd_idx_r) < eff_len)
    else $error("read index outside the ring");

  a_ctl_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(ctl.capture && ctl.execute))
    else $error("capture and execute in the same cycle");

endmodule

`default_nettype wire
